>>> hdl/passive_tcp_rtt_estimator_core_defines.svh
// assertion macros for the rtt estimator core
`ifndef PASSIVE_TCP_RTT_ESTIMATOR_CORE_DEFINES_SVH
`define PASSIVE_TCP_RTT_ESTIMATOR_CORE_DEFINES_SVH

// implication checked at every clock edge, held off during reset
`define PTRE_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// implication checked in the cycle after the trigger
`define PTRE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/ptre_pkg.sv
// shared types and constants of the rtt estimator core
`default_nettype none
package ptre_pkg;

  localparam int unsigned InDataW  = 120;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 320;
  localparam int unsigned OutUserW = 3;
  localparam logic [31:0] MaxRttReset = 32'd20000000;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic top_rd;
    logic top_chk;
    logic pop_rd;
    logic pop_chk;
    logic upd_err;
    logic upd_apply;
    logic emit;
  } ptre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dir_valid;
    logic payload_pos;
    logic fill_o_nz;
    logic fill_d_nz;
    logic pop_hit;
  } ptre_stat_t;

endpackage
`default_nettype wire

>>> hdl/ptre_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module ptre_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/ptre_ctrl.sv
// packet sequencer of the rtt estimator core
`default_nettype none
module ptre_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire ptre_pkg::ptre_stat_t stat,
  output ptre_pkg::ptre_cmd_t       cmd
);
  import ptre_pkg::*;

  typedef enum logic [3:0] {
    IDLE, DECIDE, TOP_RD, TOP_CHK, POP_RD, POP_CHK, UPD_ERR, UPD_APPLY, EMIT
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;
  logic   emit_go;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;
  assign emit_go    = (state_r == EMIT) && (!out_tvalid_r || out_tready);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.latch_in  = in_tready_r && in_tvalid;
    cmd.top_rd    = (state_r == TOP_RD);
    cmd.top_chk   = (state_r == TOP_CHK);
    cmd.pop_rd    = (state_r == POP_RD);
    cmd.pop_chk   = (state_r == POP_CHK);
    cmd.upd_err   = (state_r == UPD_ERR);
    cmd.upd_apply = (state_r == UPD_APPLY);
    cmd.emit      = emit_go;
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // result valid: set on issue, cleared when taken
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_tready_r && in_tvalid) begin
            in_tready_r <= 1'b0;
            state_r     <= DECIDE;
          end else begin
            in_tready_r <= 1'b1;
          end
        end
        DECIDE: begin
          priority if (!stat.dir_valid) begin
            state_r <= EMIT;
          end else if (!stat.payload_pos) begin
            state_r <= POP_RD;
          end else if (stat.fill_o_nz) begin
            state_r <= TOP_RD;
          end else begin
            state_r <= TOP_CHK;
          end
        end
        TOP_RD:  state_r <= TOP_CHK;
        TOP_CHK: state_r <= POP_RD;
        POP_RD: begin
          state_r <= stat.fill_d_nz ? POP_CHK : UPD_ERR;
        end
        POP_CHK: begin
          state_r <= stat.pop_hit ? POP_RD : UPD_ERR;
        end
        UPD_ERR:   state_r <= UPD_APPLY;
        UPD_APPLY: state_r <= EMIT;
        EMIT: begin
          if (emit_go) begin
            in_tready_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ptre_dp.sv
// queues, estimator state and result register of the rtt estimator core
`default_nettype none
module ptre_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [ptre_pkg::InDataW-1:0]     in_tdata,
  input  wire logic [ptre_pkg::InUserW-1:0]     in_tuser,
  input  wire logic                             cfg_valid,
  input  wire logic [31:0]                      cfg_data,
  input  wire ptre_pkg::ptre_cmd_t              cmd,
  output ptre_pkg::ptre_stat_t                  stat,
  output logic      [ptre_pkg::OutDataW-1:0]    out_tdata,
  output logic      [ptre_pkg::OutUserW-1:0]    out_tuser
);
  import ptre_pkg::*;

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(2 * QUEUE_DEPTH);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0]  CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [AddrW-1:0] DirBase = AddrW'(QUEUE_DEPTH);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // latched packet
  logic        dv_r, dir_r, pay_pos_r;
  logic [31:0] exp_r, ack_r, now_r;
  // queue pointers
  logic [PtrW-1:0] head_r [2];
  logic [PtrW-1:0] tail_r [2];
  logic [CntW-1:0] fill_r [2];
  // estimator state
  logic [34:0] srtt_r   [2];
  logic [33:0] rttvar_r [2];
  logic        est_r    [2];
  logic [47:0] sum_r    [2];
  logic [31:0] cnt_r    [2];
  logic [31:0] max_r;
  logic        popped_r, ok_r;
  logic [31:0] rtt_r, err3_r;

  logic            o;
  logic [PtrW-1:0] top_ptr;
  logic [AddrW-1:0] raddr, waddr;
  logic [63:0]     rdata;
  logic            ram_we, push;
  logic [6:0]      hdr;
  logic [15:0]     in_len;
  logic [34:0]     r8, err;
  logic [48:0]     sum_ext;

  assign o       = ~dir_r;
  assign top_ptr = (tail_r[o] == '0) ? PtrLast : tail_r[o] - 1'b1;

  // memory addressing: top of opposite queue or head of own queue
  always_comb begin
    raddr = cmd.top_rd ? (AddrW'(top_ptr) + (o ? DirBase : '0))
                       : (AddrW'(head_r[dir_r]) + (dir_r ? DirBase : '0));
    waddr = AddrW'(tail_r[o]) + (o ? DirBase : '0);
  end

  assign push   = (fill_r[o] == '0) || (exp_r > rdata[63:32]);
  assign ram_we = cmd.top_chk && push;

  ptre_ram #(.WIDTH(64), .DEPTH(2 * QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({exp_r, now_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status back to the controller
  always_comb begin
    stat.dir_valid   = dv_r;
    stat.payload_pos = pay_pos_r;
    stat.fill_o_nz   = (fill_r[o] != '0);
    stat.fill_d_nz   = (fill_r[dir_r] != '0);
    stat.pop_hit     = (ack_r >= rdata[63:32]);
  end

  assign in_len  = in_tdata[15:0];
  assign hdr     = {({1'b0, in_tdata[19:16]} + {1'b0, in_tdata[23:20]}), 2'b00};
  assign r8      = {rtt_r, 3'b000};
  assign err     = (r8 >= srtt_r[dir_r]) ? r8 - srtt_r[dir_r] : srtt_r[dir_r] - r8;
  assign sum_ext = {1'b0, sum_r[dir_r]} + 49'(rtt_r);

  // packet latch and estimator datapath
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      dv_r      <= in_tuser[0];
      dir_r     <= in_tuser[1];
      pay_pos_r <= in_len > {9'd0, hdr};
      exp_r     <= in_tdata[55:24] + {16'd0, in_len - {9'd0, hdr}};
      ack_r     <= in_tdata[87:56];
      now_r     <= in_tdata[119:88];
    end
    if (cmd.pop_chk && stat.pop_hit) begin
      rtt_r <= now_r - rdata[31:0];
    end
    if (cmd.upd_err) begin
      err3_r <= err[34:3];
    end
  end

  // control state: pointers, estimates, flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
        fill_r[i]   <= '0;
        srtt_r[i]   <= '0;
        rttvar_r[i] <= '0;
        est_r[i]    <= 1'b0;
        sum_r[i]    <= '0;
        cnt_r[i]    <= '0;
      end
      max_r    <= MaxRttReset;
      popped_r <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
      if (cmd.latch_in) begin
        popped_r <= 1'b0;
        ok_r     <= 1'b0;
      end
      // push or retransmit clear
      if (cmd.top_chk) begin
        if (push) begin
          tail_r[o] <= ring_next(tail_r[o]);
          if (fill_r[o] == CntFull) begin
            head_r[o] <= ring_next(head_r[o]);
          end else begin
            fill_r[o] <= fill_r[o] + 1'b1;
          end
        end else begin
          head_r[o] <= '0;
          tail_r[o] <= '0;
          fill_r[o] <= '0;
        end
      end
      // pop covered entry
      if (cmd.pop_chk && stat.pop_hit) begin
        popped_r      <= 1'b1;
        head_r[dir_r] <= ring_next(head_r[dir_r]);
        fill_r[dir_r] <= fill_r[dir_r] - 1'b1;
      end
      if (cmd.upd_err) begin
        ok_r <= popped_r && (rtt_r != '0) && ({1'b0, rtt_r} <= {1'b0, max_r});
      end
      // estimator update
      if (cmd.upd_apply && ok_r) begin
        sum_r[dir_r] <= sum_ext[48] ? '1 : sum_ext[47:0];
        if (cnt_r[dir_r] != '1) begin
          cnt_r[dir_r] <= cnt_r[dir_r] + 1'b1;
        end
        est_r[dir_r] <= 1'b1;
        if (!est_r[dir_r]) begin
          srtt_r[dir_r]   <= r8;
          rttvar_r[dir_r] <= {1'b0, rtt_r, 1'b0};
        end else begin
          rttvar_r[dir_r] <= rttvar_r[dir_r] - (rttvar_r[dir_r] >> 2) + 34'(err3_r);
          srtt_r[dir_r]   <= srtt_r[dir_r] - (srtt_r[dir_r] >> 3) + 35'(rtt_r);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tuser <= {est_r[1], est_r[0], ok_r};
      out_tdata <= {cnt_r[1], sum_r[1], cnt_r[0], sum_r[0],
                    rttvar_r[1][33:2], rttvar_r[0][33:2],
                    srtt_r[1][34:3], srtt_r[0][34:3],
                    ok_r ? rtt_r : 32'd0};
    end
  end

endmodule
`default_nettype wire

>>> hdl/passive_tcp_rtt_estimator_core.sv
// after accept, an ignored packet goes from DECIDE to EMIT; a packet with payload runs TOP_RD
// (only if the opposite queue is filled) and TOP_CHK; then POP_RD and POP_CHK repeat while the
// own queue head is covered by the ack, then UPD_ERR, UPD_APPLY, EMIT; the next word is taken in
// the cycle after the result is issued, even while that result waits in the output register
// reset (synchronous, rst_n low) empties both queues, clears estimates and totals
// and sets the rtt limit to 20000000 us; no clearing pass is needed
`default_nettype none
`include "passive_tcp_rtt_estimator_core_defines.svh"
module passive_tcp_rtt_estimator_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // ip_total_len, ip_header_words, tcp_header_words, seq_num, ack_num, time_us
  input  wire logic [119:0]  in_tdata,
  // direction_valid, direction
  input  wire logic [1:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // sample_us, srtt_out_us, srtt_in_us, rttvar_out_us, rttvar_in_us,
  // sum_out_us, samples_out, sum_in_us, samples_in
  output logic      [319:0]  out_tdata,
  // sample_valid, srtt_out_valid, srtt_in_valid
  output logic      [2:0]    out_tuser,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);
  import ptre_pkg::*;

  ptre_cmd_t  cmd;
  ptre_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  ptre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // queues and estimator
  ptre_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // checks
  `PTRE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "busy")
  `PTRE_ASSERT_IMPL(a_sample_nonzero, out_tvalid && out_tuser[0], out_tdata[31:0] != 32'd0, "zero")
  `PTRE_ASSERT_IMPL(a_no_sample_zero, out_tvalid && !out_tuser[0], out_tdata[31:0] == 32'd0, "flag")
  `PTRE_ASSERT_IMPL(a_srtt_out_zero, out_tvalid && !out_tuser[1], out_tdata[63:32] == 32'd0, "srtt")

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the passive tcp rtt estimator core: streamed packets checked against a local estimator
`timescale 1ns / 100ps
module tb_top;
  import ptre_pkg::*;

  localparam int Depth = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  passive_tcp_rtt_estimator_core #(.QUEUE_DEPTH(Depth)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [319:0] data;
    logic [2:0] user;
  } rtt_word_t;

  rtt_word_t rtt_words_due[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int samples_seen = 0;
  int limits_written = 0;

  // estimator state mirrored from the block
  logic [31:0] rtt_limit = MaxRttReset;
  logic [63:0] ack_ring [2][Depth];
  int ring_head [2];
  int ring_tail [2];
  int ring_fill [2];
  logic [34:0] srtt8 [2];
  logic [33:0] var4 [2];
  bit have_est [2];
  logic [47:0] rtt_sum [2];
  logic [31:0] rtt_count [2];

  // flow generator state
  logic [31:0] next_seq [2];
  logic [31:0] now_us;

  // sender and receiver idling controls
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_req = 0;
  int rx_stall = 0;

  // fold one new rtt sample into a direction's estimate
  task automatic fold_sample(input int d, input logic [31:0] r);
    logic [48:0] s;
    logic [34:0] r8, err;
    s = {1'b0, rtt_sum[d]} + r;
    rtt_sum[d] = s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    if (rtt_count[d] != 32'hFFFF_FFFF) rtt_count[d]++;
    r8 = {r, 3'b000};
    if (!have_est[d]) begin
      srtt8[d] = r8;
      var4[d] = {1'b0, r, 1'b0};
      have_est[d] = 1'b1;
    end else begin
      err = (r8 >= srtt8[d]) ? r8 - srtt8[d] : srtt8[d] - r8;
      var4[d] = var4[d] - (var4[d] >> 2) + 34'(err >> 3);
      srtt8[d] = srtt8[d] - (srtt8[d] >> 3) + 35'(r);
    end
  endtask

  // work out the result word for one accepted packet
  task automatic predict_rtt_word(input logic [1:0] u, input logic [119:0] p);
    rtt_word_t w;
    int d, o, payload, top;
    logic [31:0] seq, ack, t, expected, rtt;
    logic [63:0] e;
    bit popped, push, got;
    got = 1'b0;
    rtt = '0;
    if (u[0]) begin
      d = u[1];
      o = 1 - d;
      payload = int'(p[15:0]) - 4 * (int'(p[19:16]) + int'(p[23:20]));
      seq = p[55:24];
      ack = p[87:56];
      t = p[119:88];
      popped = 1'b0;
      if (payload > 0) begin
        expected = seq + 32'(payload);
        push = 1'b1;
        if (ring_fill[o] > 0) begin
          top = (ring_tail[o] == 0) ? Depth - 1 : ring_tail[o] - 1;
          push = expected > ack_ring[o][top][63:32];
        end
        if (push) begin
          if (ring_fill[o] >= Depth) begin
            ring_head[o] = (ring_head[o] + 1) % Depth;
            ring_fill[o]--;
          end
          ack_ring[o][ring_tail[o]] = {expected, t};
          ring_tail[o] = (ring_tail[o] + 1) % Depth;
          ring_fill[o]++;
        end else begin
          ring_head[o] = 0;
          ring_tail[o] = 0;
          ring_fill[o] = 0;
        end
      end
      while (ring_fill[d] > 0 && ack >= ack_ring[d][ring_head[d]][63:32]) begin
        e = ack_ring[d][ring_head[d]];
        rtt = t - e[31:0];
        popped = 1'b1;
        ring_head[d] = (ring_head[d] + 1) % Depth;
        ring_fill[d]--;
      end
      if (popped && rtt != 0 && rtt <= rtt_limit) begin
        got = 1'b1;
        fold_sample(d, rtt);
      end
    end
    w.user = {have_est[1], have_est[0], got};
    w.data = {rtt_count[1], rtt_sum[1], rtt_count[0], rtt_sum[0],
              32'(var4[1] >> 2), 32'(var4[0] >> 2),
              32'(srtt8[1] >> 3), 32'(srtt8[0] >> 3), got ? rtt : 32'd0};
    rtt_words_due.push_back(w);
  endtask

  // send one packet word, predicting its result on acceptance
  task automatic send_pkt(input logic [1:0] u, input logic [119:0] p);
    in_tvalid <= 1'b1;
    in_tuser <= u;
    in_tdata <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rtt_word(u, p);
    words_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic logic [119:0] pack_pkt(input int len, input int ihl, input int thl,
                                            input logic [31:0] seq, input logic [31:0] ack,
                                            input logic [31:0] t);
    return {t, ack, seq, 4'(thl), 4'(ihl), 16'(len)};
  endfunction

  // one packet of a plausible two-way flow, or occasional noise
  task automatic send_flow_pkt();
    int d, pay, sel;
    logic [31:0] seq, ack;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_pkt(2'($urandom), 120'({$urandom, $urandom, $urandom, $urandom}));
    end else begin
      d = $urandom_range(0, 1);
      pay = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1460);
      if (sel < 13) now_us += $urandom;
      else if (sel < 18) now_us += 0;
      else now_us += $urandom_range(1, 3000);
      if (sel >= 18 && sel < 24) seq = next_seq[d] - $urandom_range(1, 4000);
      else begin
        seq = next_seq[d];
        next_seq[d] += pay;
      end
      ack = ($urandom_range(0, 2) == 0) ? next_seq[1-d] - $urandom_range(0, 3000)
                                       : next_seq[1-d];
      send_pkt({1'(d), 1'b1}, pack_pkt(40 + pay, 5, 5, seq, ack, now_us));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (rtt_words_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rtt_limit = v;
    limits_written++;
  endtask

  // receiver: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_stall = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    rtt_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (rtt_words_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, out_tdata);
        errors++;
      end else begin
        w = rtt_words_due.pop_front();
        words_checked++;
        if (out_tuser[0]) samples_seen++;
        check_field("sample_valid", w.user[0], out_tuser[0]);
        check_field("srtt_out_valid", w.user[1], out_tuser[1]);
        check_field("srtt_in_valid", w.user[2], out_tuser[2]);
        check_field("sample_us", w.data[31:0], out_tdata[31:0]);
        check_field("srtt_out_us", w.data[63:32], out_tdata[63:32]);
        check_field("srtt_in_us", w.data[95:64], out_tdata[95:64]);
        check_field("rttvar_out_us", w.data[127:96], out_tdata[127:96]);
        check_field("rttvar_in_us", w.data[159:128], out_tdata[159:128]);
        check_field("sum_out_us", w.data[207:160], out_tdata[207:160]);
        check_field("samples_out", w.data[239:208], out_tdata[239:208]);
        check_field("sum_in_us", w.data[287:240], out_tdata[287:240]);
        check_field("samples_in", w.data[319:288], out_tdata[319:288]);
      end
    end
  end

  // corner packets: extremes, ignored packets, zero time, over limit, retransmit
  task automatic test_directed_cases();
    send_pkt(2'b00, '1);
    send_pkt(2'b10, '1);
    send_pkt(2'b01, pack_pkt(10, 15, 15, 32'd100, 32'd0, 32'd50));
    send_pkt(2'b01, pack_pkt(65535, 0, 0, 32'hFFFF_0000, 32'd0, 32'd1000));
    send_pkt(2'b11, pack_pkt(40, 5, 5, 32'd0, 32'hFFFF_FFFF, 32'd1500));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1000, 32'd0, 32'd2000));
    send_pkt(2'b01, pack_pkt(40, 5, 5, 32'd0, 32'd1100, 32'd2000));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1100, 32'd0, 32'd3000));
    send_pkt(2'b01, pack_pkt(40, 5, 5, 32'd0, 32'd1200, 32'd25003000));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1200, 32'd0, 32'hFFFF_FF00));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1100, 32'd0, 32'hFFFF_FF10));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1300, 32'd0, 32'hFFFF_FFF0));
    send_pkt(2'b01, pack_pkt(40, 5, 5, 32'd0, 32'd1400, 32'd300));
    send_pkt(2'b11, pack_pkt(140, 5, 5, 32'd1400, 32'd0, 32'd400));
    send_pkt(2'b01, pack_pkt(140, 5, 5, 32'd7000, 32'd1500, 32'd900));
    send_pkt(2'b11, pack_pkt(40, 5, 5, 32'd1500, 32'd7100, 32'd1700));
    send_pkt(2'b11, pack_pkt(41, 5, 5, 32'hFFFF_FFFF, 32'd0, 32'd1800));
    send_pkt(2'b01, pack_pkt(40, 5, 5, 32'd0, 32'd0, 32'd1900));
  endtask

  // more pushes than the queue holds, then one ack covering all
  task automatic test_queue_overflow();
    for (int i = 0; i < Depth + 6; i++)
      send_pkt(2'b01, pack_pkt(60, 5, 5, 32'h1000_0000 + 20 * i, 32'd0, 32'd10000 + i));
    send_pkt(2'b11, pack_pkt(40, 5, 5, 32'd0, 32'hFFFF_FFFF, 32'd20000));
  endtask

  // receiver holds off while packets keep coming
  task automatic test_backpressure();
    rx_hold_req = 400;
    repeat (30) send_flow_pkt();
    wait_drained();
  endtask

  task automatic test_random_flow(input int n);
    for (int i = 0; i < n; i++) begin
      send_flow_pkt();
      if (i % 100 == 99) wait_drained();
    end
  endtask

  // limit settings, extremes included
  task automatic test_limits();
    write_limit(32'd1);
    test_random_flow(60);
    write_limit(32'd0);
    test_random_flow(40);
    write_limit(32'hFFFF_FFFF);
    test_random_flow(80);
    write_limit(32'd2500);
    test_random_flow(60);
    write_limit(MaxRttReset);
  endtask

  initial begin
    for (int d = 0; d < 2; d++) begin
      ring_head[d] = 0; ring_tail[d] = 0; ring_fill[d] = 0;
      srtt8[d] = '0; var4[d] = '0; have_est[d] = 1'b0;
      rtt_sum[d] = '0; rtt_count[d] = '0;
      next_seq[d] = $urandom;
    end
    now_us = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_queue_overflow();
    test_backpressure();
    test_limits();
    test_random_flow(250);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_flow(80);
    in_tvalid <= 1'b0;
    while (rtt_words_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d packets, %0d result words checked, %0d rtt samples",
             words_sent, words_checked, samples_seen);
    $display("limit register written %0d times, queue overflow and receiver hold-off",
             limits_written);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ptre_pkg.sv
hdl/ptre_ram.sv
hdl/ptre_ctrl.sv
hdl/ptre_dp.sv
hdl/passive_tcp_rtt_estimator_core.sv
tb/sv/tb_top.sv
